### design/chmap_pkg.sv
// ----------------------------------------------------------------------------
// chmap_pkg - shared types and constants for the chained hash map engine
// Request and result items, request kinds, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package chmap_pkg;

  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 9;
  // key bits folded into the bucket remainder per hash step
  localparam int HASH_DIGIT  = 4;
  localparam int HASH_STEPS  = KEY_W / HASH_DIGIT;
  localparam int HASH_CNT_W  = $clog2(HASH_STEPS);

  localparam int NUM_BUCKETS_DEF = 16;
  localparam int POOL_NODES_DEF  = 256;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    KIND_PUT      = 2'd0,
    KIND_ERASE    = 2'd1,
    KIND_CONTAINS = 2'd2,
    KIND_GET      = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [VALUE_W-1:0]   read_value;
    logic                 full_res;
    logic [COUNT_W-1:0]   entry_count;
  } rsp_t;

  typedef struct packed {
    logic clear;   // write one entry of the reset clearing pass
    logic accept;  // capture a new item
    logic hash;    // one step of the bucket remainder
    logic head;    // bucket head read in flight
    logic load;    // head read data available
    logic fetch;   // node read in flight
    logic check;   // node read data available
    logic update;  // commit the item and present its result
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic head_null;
    logic walk_done;
  } sts_t;

endpackage

### design/chained_hash_map_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_map_engine - key-value map with separate chaining
// Keys hash to bucket key mod NUM_BUCKETS; each bucket heads a linked chain
// of nodes drawn from a fixed pool through a free stack.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   start_i, req_i, busy_o   taken at an edge with start_i high, busy_o low
//  result    done_o, rsp_o            valid for the one cycle that done_o is high
//
//  An item passes from acceptance to its result strobe through remainder
//  folding (4 key bits a cycle), the registered bucket head read, then a
//  fetch and a compare per chain node visited through the node memory port,
//  then a commit, from which the result strobe is registered.
//  After reset busy_o stays high while the bucket heads and the free stack
//  are initialised in one pass over max(NUM_BUCKETS, POOL_NODES) entries.
//  The result cannot be held off; the next item may be taken in its cycle.
// ----------------------------------------------------------------------------
module chained_hash_map_engine #(
  parameter int NUM_BUCKETS = chmap_pkg::NUM_BUCKETS_DEF,
  parameter int POOL_NODES  = chmap_pkg::POOL_NODES_DEF,
  parameter int KEY_BITS    = chmap_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = chmap_pkg::VALUE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  chmap_pkg::req_t req_i,
  output logic            busy_o,
  output logic            done_o,
  output chmap_pkg::rsp_t rsp_o
);

  // command and status between sequencer and datapath
  chmap_pkg::cmd_t cmd;
  chmap_pkg::sts_t sts;

  chmap_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // hold the item, walk the chain, commit and register the result
  chmap_dpath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .POOL_NODES  (POOL_NODES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

### design/chmap_ctrl.sv
// ----------------------------------------------------------------------------
// chmap_ctrl - sequencer of the chained hash map engine
// Steps through clearing, hashing, the chain walk and the commit.
// ----------------------------------------------------------------------------
module chmap_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  chmap_pkg::sts_t sts_i,
  output chmap_pkg::cmd_t cmd_o,
  output logic            busy_o
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_HASH   = 8'b0000_0100,
    ST_HEAD   = 8'b0000_1000,
    ST_LOAD   = 8'b0001_0000,
    ST_FETCH  = 8'b0010_0000,
    ST_CHECK  = 8'b0100_0000,
    ST_UPDATE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash = 1'b1;
        if (sts_i.hash_done) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        cmd_o.head = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.head_null ? ST_UPDATE : ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.walk_done ? ST_UPDATE : ST_FETCH;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> !busy_o) else $error("item taken while busy");
  a_update_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> !busy_o) else $error("no return to idle after commit");
  a_load_after_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.head |=> cmd_o.load) else $error("head read data not loaded");

endmodule

### design/chmap_dpath.sv
// ----------------------------------------------------------------------------
// chmap_dpath - datapath of the chained hash map engine
// Bucket remainder unit, bucket head, node and free stack memories,
// chain walk registers, entry count and result register.
// ----------------------------------------------------------------------------
module chmap_dpath #(
  parameter int NUM_BUCKETS = chmap_pkg::NUM_BUCKETS_DEF,
  parameter int POOL_NODES  = chmap_pkg::POOL_NODES_DEF,
  parameter int KEY_BITS    = chmap_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = chmap_pkg::VALUE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  chmap_pkg::cmd_t cmd_i,
  input  chmap_pkg::req_t req_i,
  output chmap_pkg::sts_t sts_o,
  output logic            done_o,
  output chmap_pkg::rsp_t rsp_o
);

  localparam int KEY_W = chmap_pkg::KEY_W;
  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int PW    = $clog2(POOL_NODES);
  localparam int LW    = $clog2(POOL_NODES + 1);
  localparam int KS    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VS    = (VALUE_BITS < chmap_pkg::VALUE_W) ? VALUE_BITS : chmap_pkg::VALUE_W;
  localparam int CLR_N = (NUM_BUCKETS > POOL_NODES) ? NUM_BUCKETS : POOL_NODES;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_NODES);
  localparam logic [BW:0]   NB_MOD    = (BW + 1)'(NUM_BUCKETS);

  // memories
  logic [LW-1:0] head_mem [NUM_BUCKETS];
  logic [PW-1:0] free_mem [POOL_NODES];
  logic [KS-1:0] key_mem  [POOL_NODES];
  logic [VS-1:0] val_mem  [POOL_NODES];
  logic [LW-1:0] link_mem [POOL_NODES];

  logic [LW-1:0] head_rd_q, link_rd_q;
  logic [PW-1:0] free_rd_q;
  logic [KS-1:0] key_rd_q;
  logic [VS-1:0] val_rd_q;

  // control registers
  logic [CW-1:0]                 clr_q;
  logic [chmap_pkg::HASH_CNT_W-1:0] hcnt_q;
  logic [LW-1:0]                 count_q, count_d;
  logic                          done_q;
  logic                          hit_q;

  // payload registers
  chmap_pkg::kind_e kind_q;
  logic [KS-1:0]    key_q;
  logic [VS-1:0]    val_q;
  logic [KEY_W-1:0] sh_q;
  logic [BW-1:0]    rem_q, rem_d;
  logic [LW-1:0]    cur_q, prev_q, head_q, link_q, steps_q;
  logic [PW-1:0]    node_q, free_top_q;
  logic [VS-1:0]    hval_q;
  chmap_pkg::rsp_t  rsp_q, rsp_d;

  logic          match, is_ins, room, do_ins, do_era, do_put, prev_null;
  logic [LW-1:0] push_full, pop_full;

  // fold one digit of the key into the bucket remainder
  always_comb begin
    logic [BW:0] r;
    r = {1'b0, rem_q};
    for (int i = 0; i < chmap_pkg::HASH_DIGIT; i++) begin
      r = {r[BW-1:0], sh_q[KEY_W-1-i]};
      if (r >= NB_MOD) r = r - NB_MOD;
    end
    rem_d = r[BW-1:0];
  end

  assign match     = (key_rd_q == key_q);
  assign prev_null = (prev_q == NULL_LINK);
  assign is_ins    = ((kind_q == chmap_pkg::KIND_PUT) || (kind_q == chmap_pkg::KIND_GET))
                     && !hit_q;
  assign room      = (count_q < LW'(POOL_NODES));
  assign do_ins    = cmd_i.update && is_ins && room;
  assign do_era    = cmd_i.update && (kind_q == chmap_pkg::KIND_ERASE) && hit_q;
  assign do_put    = cmd_i.update && (kind_q == chmap_pkg::KIND_PUT) && hit_q;
  assign push_full = NULL_LINK - count_q;
  assign pop_full  = NULL_LINK - LW'(1) - count_q;

  assign sts_o.clear_done = ({1'b0, clr_q} == (CW + 1)'(CLR_N - 1));
  assign sts_o.hash_done  = (hcnt_q == chmap_pkg::HASH_CNT_W'(chmap_pkg::HASH_STEPS - 1));
  assign sts_o.head_null  = (head_rd_q >= NULL_LINK);
  assign sts_o.walk_done  = match || (link_rd_q >= NULL_LINK)
                            || (steps_q == LW'(POOL_NODES - 1));

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear && ({1'b0, clr_q} < (CW + 1)'(NUM_BUCKETS))) begin
      head_mem[clr_q[BW-1:0]] <= NULL_LINK;
    end else if (do_ins) begin
      head_mem[rem_q] <= LW'(free_top_q);
    end else if (do_era && prev_null) begin
      head_mem[rem_q] <= link_q;
    end
    head_rd_q <= head_mem[rem_q];
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear && ({1'b0, clr_q} < (CW + 1)'(POOL_NODES))) begin
      free_mem[clr_q[PW-1:0]] <= clr_q[PW-1:0];
    end else if (do_era) begin
      free_mem[push_full[PW-1:0]] <= node_q;
    end
    free_rd_q <= free_mem[pop_full[PW-1:0]];
  end

  // node memories
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      key_mem[free_top_q] <= key_q;
    end
    key_rd_q <= key_mem[cur_q[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      val_mem[free_top_q] <= (kind_q == chmap_pkg::KIND_PUT) ? val_q : '0;
    end else if (do_put) begin
      val_mem[node_q] <= val_q;
    end
    val_rd_q <= val_mem[cur_q[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      link_mem[free_top_q] <= head_q;
    end else if (do_era && !prev_null) begin
      link_mem[prev_q[PW-1:0]] <= link_q;
    end
    link_rd_q <= link_mem[cur_q[PW-1:0]];
  end

  // walk and item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= req_i.kind;
      key_q  <= req_i.key[KS-1:0];
      val_q  <= req_i.value[VS-1:0];
      sh_q   <= KEY_W'(req_i.key[KS-1:0]);
      rem_q  <= '0;
    end else if (cmd_i.hash) begin
      sh_q  <= sh_q << chmap_pkg::HASH_DIGIT;
      rem_q <= rem_d;
    end
    if (cmd_i.load) begin
      cur_q      <= head_rd_q;
      head_q     <= head_rd_q;
      free_top_q <= free_rd_q;
      prev_q     <= NULL_LINK;
      steps_q    <= '0;
    end else if (cmd_i.check) begin
      if (match) begin
        node_q <= cur_q[PW-1:0];
        link_q <= link_rd_q;
        hval_q <= val_rd_q;
      end else begin
        prev_q  <= cur_q;
        cur_q   <= link_rd_q;
        steps_q <= steps_q + LW'(1);
      end
    end
    if (cmd_i.update) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + LW'(1);
    end else if (do_era && (count_q != '0)) begin
      count_d = count_q - LW'(1);
    end
    rsp_d.found       = hit_q;
    rsp_d.read_value  = (hit_q && ((kind_q == chmap_pkg::KIND_CONTAINS) ||
                                   (kind_q == chmap_pkg::KIND_GET)))
                        ? chmap_pkg::VALUE_W'(hval_q) : '0;
    rsp_d.full_res    = is_ins && !room;
    rsp_d.entry_count = chmap_pkg::COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      hcnt_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + CW'(1);
      if (cmd_i.accept) begin
        hcnt_q <= '0;
        hit_q  <= 1'b0;
      end else begin
        if (cmd_i.hash) hcnt_q <= hcnt_q + chmap_pkg::HASH_CNT_W'(1);
        if (cmd_i.check && match) hit_q <= 1'b1;
      end
      count_q <= count_d;
      done_q  <= cmd_i.update;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NULL_LINK) else $error("entry count beyond pool size");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_full_only_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.full_res) |-> (count_q == NULL_LINK))
    else $error("full flagged with free nodes left");
  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(rsp_q.found && rsp_q.full_res)) else $error("hit and full together");

endmodule
